/* hw/rtl/point_in_polygon_test_assert.svh */
// assertion macros shared by the point-in-polygon test rtl
// expects signals named clk and rst_n in the including module
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PIPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pipt_pkg.sv */
// shared types and constants for the point-in-polygon test block
// no dependencies
package pipt_pkg;

  // default corner store depth
  localparam int unsigned MAX_CORNERS_DEF = 64;

  // fixed field widths
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned IDX_W   = 6;

  // request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // one stored polygon corner
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } corner_t;

  // control token that walks the edge pipeline
  typedef struct packed {
    logic vld;
    logic is_edge;
    logic last;
  } tok_t;

endpackage

/* hw/rtl/point_in_polygon_test.sv */
// Point-in-polygon test, even-odd crossing rule over a stored corner list.
// A test primes with the last corner, then walks the corners (count clamped to the store
// depth); tokens pass the store read and stages 2 to 4 into the output register. One edge
// per cycle, set by the single read port of the corner store; loads write it directly.
// A stalled result holds the whole pipeline; no new request is taken until it is loaded.
// Reset (rst_n low, synchronous) clears vertex_count, pipeline and output;
// the corner store is not cleared and holds junk until written.
// depends on pipt_pkg and point_in_polygon_test_assert.svh
`include "point_in_polygon_test_assert.svh"

module point_in_polygon_test #(
  parameter int unsigned MAX_CORNERS = pipt_pkg::MAX_CORNERS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [pipt_pkg::CNT_W-1:0]            cfg_wr_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic [pipt_pkg::IDX_W-1:0]            in_vertex_index,
  input  logic signed [pipt_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [pipt_pkg::COORD_W-1:0]   in_coord_y,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_inside_res
);

  localparam int unsigned AW = $clog2(MAX_CORNERS);
  localparam int unsigned CW = $clog2(MAX_CORNERS + 1);
  localparam int unsigned NW = (CW > pipt_pkg::CNT_W) ? CW : pipt_pkg::CNT_W;
  localparam int unsigned CWD = pipt_pkg::COORD_W;

  // sequencer state codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PRIME = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [pipt_pkg::CNT_W-1:0] vertex_count_r;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] last_addr_r;
  logic          zero_r;
  logic signed [CWD-1:0] tp_x_r, tp_y_r;

  logic          in_acc;
  logic          adv;
  logic          res_load;
  logic [NW-1:0] cnt_ext;
  logic [CW-1:0] n_eff;

  pipt_pkg::tok_t  tok0;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;

  pipt_pkg::corner_t mem [MAX_CORNERS];
  pipt_pkg::corner_t rd_r;
  pipt_pkg::corner_t prev_r;

  pipt_pkg::tok_t s1_tok_r, s2_tok_r, s3_tok_r, s4_tok_r;

  // stage 2 values
  logic                 s2_strad_r;
  logic signed [CWD:0]  s2_a_r, s2_b_r, s2_c_r, s2_dy_r;
  // stage 3 values
  logic                 s3_strad_r, s3_neg_l_r, s3_neg_r_r;
  logic [CWD-1:0]       s3_ma_r, s3_mdy_r, s3_mb_r, s3_mc_r;
  // stage 4 values
  logic                 s4_strad_r, s4_neg_l_r, s4_neg_r_r;
  logic [2*CWD-1:0]     s4_ml_r, s4_mr_r;

  logic                 neg_a, neg_b, less, toggle;
  logic                 parity_r;
  logic                 out_valid_r, out_inside_res_r;

  logic                 strad_nxt;
  logic signed [CWD:0]  xi_e, yi_e, xj_e, yj_e, tx_e, ty_e;

  // handshake and global pipeline advance
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign adv      = !(out_valid_r && out_stall);
  assign mem_we   = in_acc && (in_op == pipt_pkg::OP_LOAD)
                    && (32'(in_vertex_index) < 32'(MAX_CORNERS));
  assign wr_addr  = AW'(in_vertex_index);

  // corner count clamped to store depth
  assign cnt_ext = NW'(vertex_count_r);
  assign n_eff   = (cnt_ext > NW'(MAX_CORNERS)) ? CW'(MAX_CORNERS) : CW'(cnt_ext);

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= '0;
    end else if (cfg_wr_en) begin
      vertex_count_r <= cfg_wr_data;
    end
  end

  // edge sequencer: prime with the last corner, then walk corners in order
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    tok0      = '0;
    rd_addr   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_op == pipt_pkg::OP_TEST)) begin
          state_nxt = ST_PRIME;
        end
      end
      ST_PRIME: begin
        tok0.vld  = 1'b1;
        tok0.last = zero_r;
        rd_addr   = last_addr_r;
        if (adv) begin
          idx_nxt   = '0;
          state_nxt = zero_r ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        tok0.vld     = 1'b1;
        tok0.is_edge = 1'b1;
        tok0.last    = (idx_r == last_addr_r);
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (tok0.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (res_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // latch test point and walk bounds on a test request
  always_ff @(posedge clk) begin
    if (in_acc && (in_op == pipt_pkg::OP_TEST)) begin
      tp_x_r      <= in_coord_x;
      tp_y_r      <= in_coord_y;
      last_addr_r <= AW'(n_eff - CW'(1));
      zero_r      <= (n_eff == '0);
    end
  end

  // corner store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= '{x: in_coord_x, y: in_coord_y};
    end
    if (adv) begin
      rd_r <= mem[rd_addr];
    end
  end

  // control tokens through the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tok_r <= '0;
      s2_tok_r <= '0;
      s3_tok_r <= '0;
      s4_tok_r <= '0;
    end else if (adv) begin
      s1_tok_r <= tok0;
      s2_tok_r <= s1_tok_r;
      s3_tok_r <= s2_tok_r;
      s4_tok_r <= s3_tok_r;
    end
  end

  // stage 2: straddle test and edge differences, corner i is rd_r, j is prev_r
  assign xi_e = $signed({rd_r.x[CWD-1], rd_r.x});
  assign yi_e = $signed({rd_r.y[CWD-1], rd_r.y});
  assign xj_e = $signed({prev_r.x[CWD-1], prev_r.x});
  assign yj_e = $signed({prev_r.y[CWD-1], prev_r.y});
  assign tx_e = $signed({tp_x_r[CWD-1], tp_x_r});
  assign ty_e = $signed({tp_y_r[CWD-1], tp_y_r});
  assign strad_nxt = (yi_e > ty_e) != (yj_e > ty_e);

  always_ff @(posedge clk) begin
    if (adv && s1_tok_r.vld) begin
      prev_r     <= rd_r;
      s2_strad_r <= strad_nxt;
      s2_dy_r    <= yj_e - yi_e;
      s2_a_r     <= tx_e - xi_e;
      s2_b_r     <= xj_e - xi_e;
      s2_c_r     <= ty_e - yi_e;
    end
  end

  // stage 3: magnitudes and product signs
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_strad_r <= s2_strad_r;
      s3_neg_l_r <= s2_a_r[CWD];
      s3_neg_r_r <= s2_b_r[CWD] ^ s2_c_r[CWD] ^ s2_dy_r[CWD];
      s3_ma_r    <= s2_a_r[CWD]  ? CWD'(-s2_a_r)  : CWD'(s2_a_r);
      s3_mdy_r   <= s2_dy_r[CWD] ? CWD'(-s2_dy_r) : CWD'(s2_dy_r);
      s3_mb_r    <= s2_b_r[CWD]  ? CWD'(-s2_b_r)  : CWD'(s2_b_r);
      s3_mc_r    <= s2_c_r[CWD]  ? CWD'(-s2_c_r)  : CWD'(s2_c_r);
    end
  end

  // stage 4: cross products |a|*|dy| and |b|*|c|
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_strad_r <= s3_strad_r;
      s4_neg_l_r <= s3_neg_l_r;
      s4_neg_r_r <= s3_neg_r_r;
      s4_ml_r    <= (2*CWD)'(s3_ma_r) * (2*CWD)'(s3_mdy_r);
      s4_mr_r    <= (2*CWD)'(s3_mb_r) * (2*CWD)'(s3_mc_r);
    end
  end

  // signed compare of the two products, a zero product counts as positive
  assign neg_a  = s4_neg_l_r && (s4_ml_r != '0);
  assign neg_b  = s4_neg_r_r && (s4_mr_r != '0);
  assign less   = (neg_a && !neg_b)
                  || (!neg_a && !neg_b && (s4_ml_r < s4_mr_r))
                  || (neg_a && neg_b && (s4_ml_r > s4_mr_r));
  assign toggle = s4_tok_r.is_edge && s4_strad_r && less;

  assign res_load = adv && s4_tok_r.vld && s4_tok_r.last;

  // parity accumulator, cleared after the last edge of a test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
    end else if (adv && s4_tok_r.vld) begin
      parity_r <= s4_tok_r.last ? 1'b0 : (parity_r ^ toggle);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_inside_res_r <= parity_r ^ toggle;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_res_r;

  // checks
  `PIPT_ASSERT_NOW(a_idle_empty, state_r == ST_IDLE,
    !(s1_tok_r.vld || s2_tok_r.vld || s3_tok_r.vld || s4_tok_r.vld),
    "pipeline holds tokens while idle")
  `PIPT_ASSERT_NOW(a_one_last,
    1'b1,
    $countones({s1_tok_r.vld && s1_tok_r.last, s2_tok_r.vld && s2_tok_r.last,
                s3_tok_r.vld && s3_tok_r.last, s4_tok_r.vld && s4_tok_r.last}) <= 1,
    "more than one final token in flight")
  `PIPT_ASSERT_NOW(a_load_in_drain, res_load, state_r == ST_DRAIN,
    "result produced outside drain state")
  `PIPT_ASSERT_NOW(a_no_overwrite, res_load, !(out_valid_r && out_stall),
    "result written over a waiting result")
  `PIPT_ASSERT_NEXT(a_test_starts, in_acc && (in_op == pipt_pkg::OP_TEST),
    state_r == ST_PRIME, "test request did not start a walk")

endmodule
